// ===== hdl/wsgf_pkg.sv =====
// Shared types and constants for the windowed sepia / grayscale filter.
// Status codes, register indexes, sepia coefficients and the divide helpers.
// No dependencies.
`default_nettype none

package wsgf_pkg;

  // Field widths fixed by the pixel format
  localparam int PixW     = 8;
  localparam int CoordW   = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  // Result status
  typedef enum logic [1:0] {
    ST_FILTERED = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_UNAVAIL  = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE       = 3'd0,
    REG_COLOR      = 3'd1,
    REG_MAX_VALUE  = 3'd2,
    REG_WIN_LEFT   = 3'd3,
    REG_WIN_TOP    = 3'd4,
    REG_WIN_RIGHT  = 3'd5,
    REG_WIN_BOTTOM = 3'd6
  } cfg_reg_e;

  // Sepia matrix in thousandths
  localparam int CoefW = 10;
  localparam logic [CoefW-1:0] K_RR = 10'd393;
  localparam logic [CoefW-1:0] K_RG = 10'd769;
  localparam logic [CoefW-1:0] K_RB = 10'd189;
  localparam logic [CoefW-1:0] K_GR = 10'd349;
  localparam logic [CoefW-1:0] K_GG = 10'd686;
  localparam logic [CoefW-1:0] K_GB = 10'd168;
  localparam logic [CoefW-1:0] K_BR = 10'd272;
  localparam logic [CoefW-1:0] K_BG = 10'd534;
  localparam logic [CoefW-1:0] K_BB = 10'd131;

  // Sepia sum incl. rounding offset: at most 1351*255+500 = 345005
  localparam int SumW = 19;
  localparam logic [SumW-1:0] RoundHalf = 19'd500;

  // n/1000 as (n * ceil(2^27/1000)) >> 27, exact for n < 2^27/272
  localparam int RecipW     = 18;
  localparam int RecipShift = 27;
  localparam logic [RecipW-1:0] Recip1000 = 18'd134218;
  localparam int QuotW      = 9;
  localparam int ProdW      = SumW + RecipW;

  // Grayscale: (r+g+b+1)/3 as (n*683)>>11, exact for n < 2048
  localparam int GraySumW = 10;
  localparam int Recip3W  = 10;
  localparam logic [Recip3W-1:0] Recip3 = 10'd683;
  localparam int Shift3   = 11;
  localparam int Prod3W   = GraySumW + Recip3W + 1;

  // One sepia channel sum with the half-up offset added
  function automatic logic [SumW-1:0] sepia_sum(
    input logic [PixW-1:0]  r,
    input logic [PixW-1:0]  g,
    input logic [PixW-1:0]  b,
    input logic [CoefW-1:0] kr,
    input logic [CoefW-1:0] kg,
    input logic [CoefW-1:0] kb
  );
    return SumW'(kr) * SumW'(r) + SumW'(kg) * SumW'(g) +
           SumW'(kb) * SumW'(b) + RoundHalf;
  endfunction

  // Quotient by 1000 through the reciprocal
  function automatic logic [QuotW-1:0] div1000(input logic [SumW-1:0] n);
    logic [ProdW-1:0] p;
    p = ProdW'(n) * ProdW'(Recip1000);
    return p[RecipShift +: QuotW];
  endfunction

  // Quotient by 3 through the reciprocal
  function automatic logic [PixW-1:0] div3(input logic [GraySumW-1:0] n);
    logic [Prod3W-1:0] p;
    p = Prod3W'(n) * Prod3W'(Recip3);
    return p[Shift3 +: PixW];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/windowed_sepia_grayscale_filter.sv =====
// Windowed sepia / grayscale pixel filter, top level.
// Stages: input, product and result registers, passed through in that order.
// Throughput: one item per cycle while out_ready_i is high; the three stages advance independently.
// Reset: config registers take their defaults (grayscale, color, max 255, full
// window) and all stages are emptied. Depends on wsgf_pkg.
`default_nettype none

module windowed_sepia_grayscale_filter
  import wsgf_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // pixel input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [CoordW-1:0]   pixel_column_i,
  input  wire logic [CoordW-1:0]   pixel_row_i,
  input  wire logic [PixW-1:0]     red_in_i,
  input  wire logic [PixW-1:0]     green_in_i,
  input  wire logic [PixW-1:0]     blue_in_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [PixW-1:0]          red_out_o,
  output logic [PixW-1:0]          green_out_o,
  output logic [PixW-1:0]          blue_out_o,
  output logic [1:0]               status_o
);

  // Window edges are stored already saturated to MAX_DIM
  localparam int DimW = 17;
  localparam int WinW = $clog2(MAX_DIM + 1);
  localparam int CmpW = (WinW > CoordW) ? WinW : CoordW;
  localparam logic [DimW-1:0] MaxDimV = DimW'(MAX_DIM);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic            mode_q;
  logic            color_q;
  logic [PixW-1:0] max_value_q;
  logic [WinW-1:0] win_left_q, win_top_q, win_right_q, win_bottom_q;

  logic [DimW-1:0] cfg_ext;
  logic [WinW-1:0] cfg_win;

  always_comb begin
    cfg_ext = DimW'(cfg_wdata_i);
    cfg_win = (cfg_ext > MaxDimV) ? WinW'(MaxDimV) : WinW'(cfg_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      color_q      <= 1'b1;
      max_value_q  <= '1;
      win_left_q   <= '0;
      win_top_q    <= '0;
      win_right_q  <= WinW'(MaxDimV);
      win_bottom_q <= WinW'(MaxDimV);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:       mode_q       <= cfg_wdata_i[0];
        REG_COLOR:      color_q      <= cfg_wdata_i[0];
        REG_MAX_VALUE:  max_value_q  <= cfg_wdata_i[PixW-1:0];
        REG_WIN_LEFT:   win_left_q   <= cfg_win;
        REG_WIN_TOP:    win_top_q    <= cfg_win;
        REG_WIN_RIGHT:  win_right_q  <= cfg_win;
        REG_WIN_BOTTOM: win_bottom_q <= cfg_win;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: each stage loads when empty or when the next one moves
  // ---------------------------------------------------------------------------
  logic in_valid_q, mid_valid_q, out_valid_q;
  logic in_en, mid_en, out_en;

  assign out_en     = !out_valid_q || out_ready_i;
  assign mid_en     = !mid_valid_q || out_en;
  assign in_en      = !in_valid_q  || mid_en;
  assign in_ready_o = in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_en)  in_valid_q  <= in_valid_i;
      if (mid_en) mid_valid_q <= in_valid_q;
      if (out_en) out_valid_q <= mid_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic [CoordW-1:0] col_q, row_q;
  logic [PixW-1:0]   r_q, g_q, b_q;

  always_ff @(posedge clk_i) begin
    if (in_en && in_valid_i) begin
      col_q <= pixel_column_i;
      row_q <= pixel_row_i;
      r_q   <= red_in_i;
      g_q   <= green_in_i;
      b_q   <= blue_in_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: window test, status, sepia products and grayscale sum
  // ---------------------------------------------------------------------------
  logic    in_window;
  status_e st_d;

  always_comb begin
    in_window = (CmpW'(col_q) >= CmpW'(win_left_q)) && (CmpW'(col_q) < CmpW'(win_right_q)) &&
                (CmpW'(row_q) >= CmpW'(win_top_q))  && (CmpW'(row_q) < CmpW'(win_bottom_q));
    if (!color_q)        st_d = ST_UNAVAIL;
    else if (!in_window) st_d = ST_OUTSIDE;
    else                 st_d = ST_FILTERED;
  end

  status_e           mid_st_q;
  logic              mid_mode_q;
  logic [PixW-1:0]   mid_r_q, mid_g_q, mid_b_q;
  logic [SumW-1:0]   sum_r_q, sum_g_q, sum_b_q;
  logic [GraySumW-1:0] gray_sum_q;

  always_ff @(posedge clk_i) begin
    if (mid_en && in_valid_q) begin
      mid_st_q   <= st_d;
      mid_mode_q <= mode_q;
      mid_r_q    <= r_q;
      mid_g_q    <= g_q;
      mid_b_q    <= b_q;
      sum_r_q    <= sepia_sum(r_q, g_q, b_q, K_RR, K_RG, K_RB);
      sum_g_q    <= sepia_sum(r_q, g_q, b_q, K_GR, K_GG, K_GB);
      sum_b_q    <= sepia_sum(r_q, g_q, b_q, K_BR, K_BG, K_BB);
      gray_sum_q <= GraySumW'(r_q) + GraySumW'(g_q) + GraySumW'(b_q) + GraySumW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divide, clamp and select into the result register
  // ---------------------------------------------------------------------------
  logic [QuotW-1:0] q_r, q_g, q_b;
  logic [QuotW-1:0] max_ext;
  logic [PixW-1:0]  sep_r, sep_g, sep_b, gray;
  logic [PixW-1:0]  red_d, green_d, blue_d;

  always_comb begin
    q_r     = div1000(sum_r_q);
    q_g     = div1000(sum_g_q);
    q_b     = div1000(sum_b_q);
    max_ext = QuotW'(max_value_q);
    sep_r   = (q_r > max_ext) ? max_value_q : q_r[PixW-1:0];
    sep_g   = (q_g > max_ext) ? max_value_q : q_g[PixW-1:0];
    sep_b   = (q_b > max_ext) ? max_value_q : q_b[PixW-1:0];
    gray    = div3(gray_sum_q);
    // pass-through unless filtered
    red_d   = mid_r_q;
    green_d = mid_g_q;
    blue_d  = mid_b_q;
    if (mid_st_q == ST_FILTERED) begin
      if (mid_mode_q) begin
        red_d   = sep_r;
        green_d = sep_g;
        blue_d  = sep_b;
      end else begin
        red_d   = gray;
        green_d = gray;
        blue_d  = gray;
      end
    end
  end

  logic [PixW-1:0] red_q, green_q, blue_q;
  status_e         out_st_q;

  always_ff @(posedge clk_i) begin
    if (out_en && mid_valid_q) begin
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      out_st_q <= mid_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign status_o    = out_st_q;

endmodule

`default_nettype wire

// ===== test/tb_windowed_sepia_grayscale_filter.sv =====
// Self-checking testbench for windowed_sepia_grayscale_filter: random pixel stream,
// random handshake idling and a long receiver stall, results checked against a model.
// Depends on wsgf_pkg and the filter top level.
`timescale 1ns / 1ps

module tb_windowed_sepia_grayscale_filter;
  import wsgf_pkg::*;

  localparam int MaxDim        = 4096;
  localparam int CycleLimit    = 400000;
  localparam int RandPhases    = 10;
  localparam int ItemsPerPhase = 115;
  localparam int ReportLimit   = 10;
  localparam int StallCycles   = 300;
  localparam int DrainCycles   = 10;

  // index past the last register, writes to it are dropped
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  // sepia matrix in thousandths, rows are output channels
  localparam int unsigned SepRr = 393, SepRg = 769, SepRb = 189;
  localparam int unsigned SepGr = 349, SepGg = 686, SepGb = 168;
  localparam int unsigned SepBr = 272, SepBg = 534, SepBb = 131;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [PixW-1:0]   red;
    logic [PixW-1:0]   green;
    logic [PixW-1:0]   blue;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    status_e         status;
  } pixel_result_t;

  // Register copy, filter model and the queue of results still due
  class pixel_ledger;
    bit                mode_sepia;
    bit                color_image;
    bit [PixW-1:0]     max_value;
    bit [CfgDataW-1:0] win_left, win_top, win_right, win_bottom;
    pixel_result_t     pixels_due[$];
    int unsigned       mismatches;

    function new();
      mode_sepia  = 1'b0;
      color_image = 1'b1;
      max_value   = 8'd255;
      win_left    = '0;
      win_top     = '0;
      win_right   = CfgDataW'(MaxDim);
      win_bottom  = CfgDataW'(MaxDim);
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (cfg_reg_e'(idx))
        REG_MODE:       mode_sepia  = data[0];
        REG_COLOR:      color_image = data[0];
        REG_MAX_VALUE:  max_value   = data[PixW-1:0];
        REG_WIN_LEFT:   win_left    = data;
        REG_WIN_TOP:    win_top     = data;
        REG_WIN_RIGHT:  win_right   = data;
        REG_WIN_BOTTOM: win_bottom  = data;
        default: ;
      endcase
    endfunction

    // window edges beyond the image are pulled back to its size
    function int unsigned clip_dim(bit [CfgDataW-1:0] v);
      return (v > MaxDim) ? MaxDim : v;
    endfunction

    // rounded half up, then clamped to max_value
    function bit [PixW-1:0] sepia_tone(bit [PixW-1:0] r, bit [PixW-1:0] g,
                                       bit [PixW-1:0] b, int unsigned kr,
                                       int unsigned kg, int unsigned kb);
      int unsigned q;
      q = (kr * r + kg * g + kb * b + 500) / 1000;
      return (q > max_value) ? max_value : q[PixW-1:0];
    endfunction

    function pixel_result_t filter_pixel(pixel_t p);
      pixel_result_t res;
      int unsigned   avg;
      bit            in_window;
      in_window = p.col >= clip_dim(win_left) && p.col < clip_dim(win_right) &&
                  p.row >= clip_dim(win_top) && p.row < clip_dim(win_bottom);
      res.red   = p.red;
      res.green = p.green;
      res.blue  = p.blue;
      if (!color_image) begin
        res.status = ST_UNAVAIL;
      end else if (!in_window) begin
        res.status = ST_OUTSIDE;
      end else begin
        res.status = ST_FILTERED;
        if (mode_sepia) begin
          res.red   = sepia_tone(p.red, p.green, p.blue, SepRr, SepRg, SepRb);
          res.green = sepia_tone(p.red, p.green, p.blue, SepGr, SepGg, SepGb);
          res.blue  = sepia_tone(p.red, p.green, p.blue, SepBr, SepBg, SepBb);
        end else begin
          // average of the three channels, half up
          avg = (p.red + p.green + p.blue + 1) / 3;
          res.red   = avg[PixW-1:0];
          res.green = avg[PixW-1:0];
          res.blue  = avg[PixW-1:0];
        end
      end
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      pixels_due.push_back(filter_pixel(p));
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("ERROR: result with none due: rgb %0d/%0d/%0d status %0d",
                   got.red, got.green, got.blue, got.status);
        return;
      end
      want = pixels_due.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("ERROR: expected rgb %0d/%0d/%0d status %0d, got rgb %0d/%0d/%0d status %0d",
                   want.red, want.green, want.blue, want.status,
                   got.red, got.green, got.blue, got.status);
      end
    endfunction

    function int unsigned pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CoordW-1:0]   pixel_column_i;
  logic [CoordW-1:0]   pixel_row_i;
  logic [PixW-1:0]     red_in_i;
  logic [PixW-1:0]     green_in_i;
  logic [PixW-1:0]     blue_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [PixW-1:0]     red_out_o;
  logic [PixW-1:0]     green_out_o;
  logic [PixW-1:0]     blue_out_o;
  logic [1:0]          status_o;

  pixel_ledger ledger;
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 83;
  int unsigned hold_left     = 0;

  windowed_sepia_grayscale_filter #(.MAX_DIM(MaxDim)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one pixel after a random gap and hold it until accepted
  task automatic send_pixel(int unsigned col, int unsigned row, int unsigned r,
                            int unsigned g, int unsigned b);
    pixel_t      px;
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    px.col   = CoordW'(col);
    px.row   = CoordW'(row);
    px.red   = PixW'(r);
    px.green = PixW'(g);
    px.blue  = PixW'(b);
    in_valid_i     <= 1'b1;
    pixel_column_i <= px.col;
    pixel_row_i    <= px.row;
    red_in_i       <= px.red;
    green_in_i     <= px.green;
    blue_in_i      <= px.blue;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    ledger.note_pixel(px);
  endtask

  // Stop offering and wait for every due result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    ledger.write_reg(idx, data);
  endtask

  // Full register set, written only once the filter is empty
  task automatic apply_config(logic [CfgDataW-1:0] mode_v, logic [CfgDataW-1:0] color_v,
                              logic [CfgDataW-1:0] max_v, logic [CfgDataW-1:0] left_v,
                              logic [CfgDataW-1:0] top_v, logic [CfgDataW-1:0] right_v,
                              logic [CfgDataW-1:0] bottom_v);
    wait_idle();
    write_reg(REG_MODE, mode_v);
    write_reg(REG_COLOR, color_v);
    write_reg(REG_MAX_VALUE, max_v);
    write_reg(REG_WIN_LEFT, left_v);
    write_reg(REG_WIN_TOP, top_v);
    write_reg(REG_WIN_RIGHT, right_v);
    write_reg(REG_WIN_BOTTOM, bottom_v);
    write_reg(RegUnused, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Coordinate biased toward the window interior and its edges
  function automatic int unsigned pick_coord(logic [CfgDataW-1:0] lo_reg,
                                             logic [CfgDataW-1:0] hi_reg);
    int lo, hi, v;
    lo = (lo_reg > MaxDim) ? MaxDim : int'(lo_reg);
    hi = (hi_reg > MaxDim) ? MaxDim : int'(hi_reg);
    case ($urandom_range(0, 3))
      0, 1: v = (lo < hi) ? int'($urandom_range(lo, hi - 1)) : int'($urandom_range(0, 4095));
      2: begin
        case ($urandom_range(0, 3))
          0: v = lo - 1;
          1: v = lo;
          2: v = hi - 1;
          default: v = hi;
        endcase
      end
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  function automatic int unsigned pick_chan();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Result side: check accepted items, then pick next ready
  initial begin
    pixel_result_t got;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        got.red    = red_out_o;
        got.green  = green_out_o;
        got.blue   = blue_out_o;
        got.status = status_e'(status_o);
        ledger.check_result(got);
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("windowed_sepia_grayscale_filter: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    logic [CfgDataW-1:0] mode_v, color_v, max_v, win_l, win_t, win_r, win_b;
    ledger         = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_MODE;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    pixel_column_i = '0;
    pixel_row_i    = '0;
    red_in_i       = '0;
    green_in_i     = '0;
    blue_in_i      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: grayscale, full window; extremes and half-up average
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(4095, 4095, 255, 255, 255);
    send_pixel(2048, 1, 1, 0, 0);
    send_pixel(1, 2048, 1, 1, 0);
    send_pixel(4094, 5, 255, 0, 0);

    // sepia at full range, white clamps
    apply_config(1, 1, 255, 0, 0, MaxDim, MaxDim);
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(100, 100, 255, 0, 0);
    send_pixel(5, 5, 0, 255, 0);
    send_pixel(7, 7, 0, 0, 255);
    send_pixel(9, 9, 0, 0, 0);

    // sepia with max zero, pixels on and just past each window edge
    apply_config(1, 1, 0, 10, 20, 30, 40);
    send_pixel(10, 20, 200, 100, 50);
    send_pixel(9, 25, 200, 100, 50);
    send_pixel(29, 39, 17, 34, 51);
    send_pixel(30, 25, 1, 2, 3);
    send_pixel(15, 19, 4, 5, 6);
    send_pixel(15, 40, 7, 8, 9);

    // not a color image
    apply_config(0, 0, 255, 0, 0, MaxDim, MaxDim);
    send_pixel(0, 0, 10, 20, 30);
    send_pixel(4095, 4095, 255, 255, 255);

    // inverted window selects nothing
    apply_config(0, 1, 255, 100, 0, 50, MaxDim);
    send_pixel(75, 10, 60, 70, 80);

    // upper data bits ignored, window edges above image size saturate
    apply_config(13'h1FFE, 13'h1FFF, 13'h1F80, 0, 0, 13'h1FFF, 13'h1FFF);
    send_pixel(4095, 4095, 200, 200, 200);
    send_pixel(4095, 0, 255, 255, 0);

    // left edge saturates onto the right edge: empty
    apply_config(1, 1, 255, 13'h1FFF, 0, 13'h1FFF, MaxDim);
    send_pixel(4095, 100, 9, 9, 9);

    // random settings per phase, random pixels biased around the window
    for (int phase = 0; phase < RandPhases; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 23;
      end
      if (phase == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mode_v  = CfgDataW'($urandom);
      color_v = {12'($urandom), 1'($urandom_range(0, 7) != 0)};
      case ($urandom_range(0, 2))
        0: max_v = {5'($urandom), 8'd255};
        1: max_v = {5'($urandom), 8'd0};
        default: max_v = CfgDataW'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: begin
          win_l = 0;
          win_t = 0;
          win_r = MaxDim;
          win_b = MaxDim;
        end
        1: begin
          win_l = 0;
          win_t = 0;
          win_r = CfgDataW'($urandom_range(4096, 8191));
          win_b = CfgDataW'($urandom_range(4096, 8191));
        end
        4: begin
          win_l = CfgDataW'($urandom_range(1, 4096));
          win_r = CfgDataW'($urandom_range(0, win_l));
          win_t = CfgDataW'($urandom_range(0, 4095));
          win_b = CfgDataW'($urandom_range(0, 8191));
        end
        5: begin
          win_l = CfgDataW'($urandom_range(4000, 4095));
          win_r = MaxDim;
          win_t = 0;
          win_b = CfgDataW'($urandom_range(1, 96));
        end
        default: begin
          win_l = CfgDataW'($urandom_range(0, 4000));
          win_r = win_l + CfgDataW'($urandom_range(1, 600));
          win_t = CfgDataW'($urandom_range(0, 4000));
          win_b = win_t + CfgDataW'($urandom_range(1, 600));
        end
      endcase
      if (phase == 0) begin
        mode_v  = 1;
        color_v = 1;
        max_v   = 255;
        win_l   = 0;
        win_t   = 0;
        win_r   = MaxDim;
        win_b   = MaxDim;
      end
      if (phase == 1) begin
        mode_v[0]       = 1'b1;
        color_v[0]      = 1'b1;
        max_v[PixW-1:0] = '0;
      end
      apply_config(mode_v, color_v, max_v, win_l, win_t, win_r, win_b);
      // long receiver stall while the sender keeps offering
      if (phase == 7) hold_left = StallCycles;
      repeat (ItemsPerPhase)
        send_pixel(pick_coord(ledger.win_left, ledger.win_right),
                   pick_coord(ledger.win_top, ledger.win_bottom),
                   pick_chan(), pick_chan(), pick_chan());
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending() == 0)
      $display("windowed_sepia_grayscale_filter: match");
    else
      $display("windowed_sepia_grayscale_filter: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wsgf_pkg.sv
hdl/windowed_sepia_grayscale_filter.sv
test/tb_windowed_sepia_grayscale_filter.sv
